// ----- rtl/lpg_pkg.sv -----
// Package with the payload types, mode codes and pattern functions of the LED pattern generator.
package lpg_pkg;

   localparam int LED_NUM_DEFAULT = 2;
   localparam int LED_NUM_MAX     = 8;

   localparam logic       KIND_TICK = 1'b0;
   localparam logic       KIND_SET  = 1'b1;

   localparam logic [2:0] MODE_OFF     = 3'd0;
   localparam logic [2:0] MODE_ON      = 3'd1;
   localparam logic [2:0] MODE_SLOW    = 3'd2;
   localparam logic [2:0] MODE_FAST    = 3'd3;
   localparam logic [2:0] MODE_BREATHE = 3'd4;

   localparam logic [9:0] FULL_LEVEL  = 10'd1000;
   localparam logic [6:0] SLOW_LAST   = 7'd99;
   localparam logic [6:0] SLOW_LIT    = 7'd50;
   localparam logic [4:0] FAST_LAST   = 5'd23;
   localparam logic [4:0] FAST_LIT    = 5'd12;
   localparam logic [1:0] BREATHE_SUB = 2'd3;
   localparam logic [5:0] BREATHE_END = 6'd49;

   typedef struct packed {
      logic       kind;
      logic [2:0] led_index;
      logic [2:0] mode;
   } lpg_req_type;

   typedef struct packed {
      logic [2:0] led_number;
      logic [9:0] level;
      logic [2:0] current_mode;
      logic       last;
   } lpg_rsp_type;

   // Per LED state: the mode and the phase split into the position within each pattern.
   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] slow_pos;
      logic [4:0] fast_pos;
      logic [1:0] sub_pos;
      logic [5:0] breathe_pos;
   } lpg_state_type;

   typedef struct packed {
      logic       load;
      logic [2:0] mode;
   } lpg_set_type;

   function automatic logic [9:0] breathe_level(input logic [5:0] idx);
      logic [9:0] v;
      case (idx)
         6'd0:  v = 10'd0;    6'd1:  v = 10'd63;   6'd2:  v = 10'd125;  6'd3:  v = 10'd187;
         6'd4:  v = 10'd249;  6'd5:  v = 10'd309;  6'd6:  v = 10'd368;  6'd7:  v = 10'd426;
         6'd8:  v = 10'd482;  6'd9:  v = 10'd536;  6'd10: v = 10'd588;  6'd11: v = 10'd637;
         6'd12: v = 10'd685;  6'd13: v = 10'd729;  6'd14: v = 10'd771;  6'd15: v = 10'd809;
         6'd16: v = 10'd844;  6'd17: v = 10'd876;  6'd18: v = 10'd905;  6'd19: v = 10'd930;
         6'd20: v = 10'd951;  6'd21: v = 10'd969;  6'd22: v = 10'd982;  6'd23: v = 10'd992;
         6'd24: v = 10'd998;  6'd25: v = 10'd1000; 6'd26: v = 10'd998;  6'd27: v = 10'd992;
         6'd28: v = 10'd982;  6'd29: v = 10'd969;  6'd30: v = 10'd951;  6'd31: v = 10'd930;
         6'd32: v = 10'd905;  6'd33: v = 10'd876;  6'd34: v = 10'd844;  6'd35: v = 10'd809;
         6'd36: v = 10'd771;  6'd37: v = 10'd729;  6'd38: v = 10'd685;  6'd39: v = 10'd637;
         6'd40: v = 10'd588;  6'd41: v = 10'd536;  6'd42: v = 10'd482;  6'd43: v = 10'd426;
         6'd44: v = 10'd368;  6'd45: v = 10'd309;  6'd46: v = 10'd249;  6'd47: v = 10'd187;
         6'd48: v = 10'd125;  6'd49: v = 10'd63;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

   function automatic logic [9:0] level_of(input lpg_state_type s);
      logic [9:0] v;
      case (s.mode)
         MODE_OFF:     v = 10'd0;
         MODE_ON:      v = FULL_LEVEL;
         MODE_SLOW:    v = (s.slow_pos < SLOW_LIT) ? FULL_LEVEL : 10'd0;
         MODE_FAST:    v = (s.fast_pos < FAST_LIT) ? FULL_LEVEL : 10'd0;
         MODE_BREATHE: v = breathe_level(s.breathe_pos);
         default:      v = 10'd0;
      endcase
      return v;
   endfunction

   function automatic lpg_state_type advance(input lpg_state_type s);
      lpg_state_type n;
      n = s;
      n.slow_pos = (s.slow_pos == SLOW_LAST) ? 7'd0 : s.slow_pos + 7'd1;
      n.fast_pos = (s.fast_pos == FAST_LAST) ? 5'd0 : s.fast_pos + 5'd1;
      n.sub_pos  = s.sub_pos + 2'd1;
      if (s.sub_pos == BREATHE_SUB) begin
         n.breathe_pos = (s.breathe_pos == BREATHE_END) ? 6'd0 : s.breathe_pos + 6'd1;
      end
      return n;
   endfunction

endpackage

// ----- rtl/lpg_cell.sv -----
// One LED cell of the rotating state ring: holds mode and pattern positions.
module lpg_cell import lpg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lpg_set_type   set,
   input  logic          shift,
   input  lpg_state_type shift_data,
   output lpg_state_type state
);

   lpg_state_type state_ff;
   lpg_state_type state_in;

   always_comb begin
      state_in = state_ff;
      if (set.load) begin
         state_in      = '0;
         state_in.mode = set.mode;
      end else if (shift) begin
         state_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ----- rtl/led_pattern_generator_top.sv -----
// Top level of the LED pattern generator: request decode, cell ring, output register.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    lpg_req_type (kind, led_index, mode)
//   rsp      out        rsp_valid/stall    lpg_rsp_type (led_number, level, mode, last)
//   csr      in         csr_valid/ready    pwm_capable_mask, 8 bits
//
// A set transaction loads one cell's mode and clears its phases. A tick is accepted, then
// the cell ring rotates one place per LED, emitting one result for each LED.
// Reset clears all modes and phases to zero and sets the mask to all ones.
// A stall on rsp holds the ring in place; req stays stalled until a tick's last LED result is emitted.
module led_pattern_generator_top import lpg_pkg::*; #(
   parameter int LED_NUM = LED_NUM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lpg_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lpg_rsp_type rsp,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int CNT_W = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LED_NUM - 1);

   logic [7:0]       mask_ff;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lpg_rsp_type      rsp_ff, rsp_in;

   logic             req_take;
   logic             step;
   logic             step_last;
   logic [2:0]       set_mode;
   lpg_state_type    cell_state [LED_NUM];

   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;
   assign step      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign step_last = step && (cnt_ff == CNT_LAST);
   assign csr_ready = 1'b1;

   assign set_mode = (req.mode == MODE_BREATHE && !mask_ff[req.led_index]) ? MODE_ON : req.mode;

   for (genvar k = 0; k < LED_NUM; k++) begin : g_cell
      lpg_set_type   cell_set;
      lpg_state_type cell_next;

      assign cell_set.load = req_take && (req.kind == KIND_SET) && (req.led_index == 3'(k));
      assign cell_set.mode = set_mode;

      if (k == LED_NUM - 1) begin : g_tail
         assign cell_next = advance(cell_state[0]);
      end else begin : g_body
         assign cell_next = cell_state[k+1];
      end

      lpg_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .set        (cell_set),
         .shift      (step),
         .shift_data (cell_next),
         .state      (cell_state[k])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (req_take && req.kind == KIND_TICK) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (step) begin
         cnt_in = step_last ? '0 : cnt_ff + 1'b1;
         if (step_last) begin
            busy_in = 1'b0;
         end
      end

      rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (step) begin
         rsp_in.led_number   = 3'(cnt_ff);
         rsp_in.level        = level_of(cell_state[0]);
         rsp_in.current_mode = cell_state[0].mode;
         rsp_in.last         = (cnt_ff == CNT_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= 8'hFF;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_data;
         end
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      req_take && req.kind == KIND_TICK |=> busy_ff && cnt_ff == '0)
      else $error("Accepted tick did not start the LED sweep.");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      step_last |=> !busy_ff && rsp_valid_ff && rsp_ff.last)
      else $error("Final LED of a tick did not end the sweep.");

   a_last_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> rsp_ff.led_number == 3'(LED_NUM - 1))
      else $error("Last flag on a result that is not the final LED.");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0)
      else $error("LED counter is not zero while idle.");

endmodule
